// ----- rtl/core/perspective_coordinate_map_macros.svh -----
// assertion macros for the perspective coordinate map checker
`ifndef PERSPECTIVE_COORDINATE_MAP_MACROS_SVH
`define PERSPECTIVE_COORDINATE_MAP_MACROS_SVH

// clocked assertion, disabled while in reset
`define PCM_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define PCM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pcm_pkg.sv -----
package pcm_pkg;

  localparam int COEF_W = 32;
  localparam int SUM_W = 42;
  localparam int MAG_W = 41;
  localparam int Q_W = 16;
  localparam int DIV_STAGES = Q_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam int SRC_COLS_DEF = 256;
  localparam int SRC_ROWS_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] REG_X_LINEAR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LINEAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W_LINEAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_W_OFFSET = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd1048576;

  typedef struct packed {
    logic signed [COEF_W-1:0] xc;
    logic signed [COEF_W-1:0] xr;
    logic signed [COEF_W-1:0] yc;
    logic signed [COEF_W-1:0] yr;
    logic signed [COEF_W-1:0] wc;
    logic signed [COEF_W-1:0] wr;
    logic signed [COEF_W-1:0] xo;
    logic signed [COEF_W-1:0] yo;
    logic signed [COEF_W-1:0] wo;
  } coef_t;

  typedef struct packed {
    logic [MAG_W-1:0] nx;
    logic [MAG_W-1:0] ny;
    logic [MAG_W-1:0] d;
    logic             negx;
    logic             negy;
    logic             zero;
  } mag_t;

  typedef struct packed {
    logic [MAG_W-1:0] rx;
    logic [MAG_W-1:0] ry;
    logic [MAG_W-1:0] d;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic             ovx;
    logic             ovy;
    logic             negx;
    logic             negy;
    logic             zero;
  } div_t;

endpackage

// ----- rtl/core/pcm_front.sv -----
module pcm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  pcm_pkg::coef_t coef,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     col,
  input  logic [7:0]     row,
  output logic           out_valid,
  input  logic           out_ready,
  output pcm_pkg::mag_t  out_mag
);

  logic                               a_valid_r;
  logic signed [pcm_pkg::SUM_W-1:0]   nx_r, ny_r, d_r;
  logic signed [pcm_pkg::SUM_W-1:0]   nx_nxt, ny_nxt, d_nxt;
  logic                               b_valid_r;
  pcm_pkg::mag_t                      mag_r, mag_nxt;
  logic                               a_adv, b_adv;
  logic signed [8:0]                  col_s, row_s;

  assign b_adv = !b_valid_r || out_ready;
  assign a_adv = !a_valid_r || b_adv;
  assign in_ready = a_adv;
  assign col_s = $signed({1'b0, col});
  assign row_s = $signed({1'b0, row});

  // exact products and sums
  always_comb begin
    nx_nxt = pcm_pkg::SUM_W'(coef.xc) * col_s + pcm_pkg::SUM_W'(coef.xr) * row_s
           + pcm_pkg::SUM_W'(coef.xo);
    ny_nxt = pcm_pkg::SUM_W'(coef.yc) * col_s + pcm_pkg::SUM_W'(coef.yr) * row_s
           + pcm_pkg::SUM_W'(coef.yo);
    d_nxt  = pcm_pkg::SUM_W'(coef.wc) * col_s + pcm_pkg::SUM_W'(coef.wr) * row_s
           + pcm_pkg::SUM_W'(coef.wo);
  end

  // magnitudes and signs
  always_comb begin
    mag_nxt.nx = pcm_pkg::MAG_W'(nx_r[pcm_pkg::SUM_W-1] ? -nx_r : nx_r);
    mag_nxt.ny = pcm_pkg::MAG_W'(ny_r[pcm_pkg::SUM_W-1] ? -ny_r : ny_r);
    mag_nxt.d  = pcm_pkg::MAG_W'(d_r[pcm_pkg::SUM_W-1] ? -d_r : d_r);
    mag_nxt.negx = nx_r[pcm_pkg::SUM_W-1] ^ d_r[pcm_pkg::SUM_W-1];
    mag_nxt.negy = ny_r[pcm_pkg::SUM_W-1] ^ d_r[pcm_pkg::SUM_W-1];
    mag_nxt.zero = (d_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_adv) a_valid_r <= in_valid;
      if (b_adv) b_valid_r <= a_valid_r;
    end
    if (a_adv && in_valid) begin
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
      d_r <= d_nxt;
    end
    if (b_adv && a_valid_r) mag_r <= mag_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_mag = mag_r;

endmodule

// ----- rtl/core/pcm_div.sv -----
module pcm_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcm_pkg::mag_t in_mag,
  output logic          out_valid,
  input  logic          out_ready,
  output pcm_pkg::div_t out_div
);

  localparam int NS = pcm_pkg::DIV_STAGES;
  localparam int WW = pcm_pkg::MAG_W + pcm_pkg::Q_W;

  logic [NS:0]   rdy;
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  pcm_pkg::div_t st_r [NS];
  pcm_pkg::div_t st_in [NS];
  pcm_pkg::div_t st_nxt [NS];

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    logic [WW-1:0] dsh;
    dsh = '0;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        v_in[k] = in_valid;
        st_in[k].rx = in_mag.nx;
        st_in[k].ry = in_mag.ny;
        st_in[k].d = in_mag.d;
        st_in[k].qx = '0;
        st_in[k].qy = '0;
        st_in[k].ovx = 1'b0;
        st_in[k].ovy = 1'b0;
        st_in[k].negx = in_mag.negx;
        st_in[k].negy = in_mag.negy;
        st_in[k].zero = in_mag.zero;
      end else begin
        v_in[k] = v_r[k-1];
        st_in[k] = st_r[k-1];
      end
      st_nxt[k] = st_in[k];
      if (k == 0) begin
        // quotient of 2^16 or more saturates
        dsh = WW'(st_in[k].d) << pcm_pkg::Q_W;
        st_nxt[k].ovx = WW'(st_in[k].rx) >= dsh;
        st_nxt[k].ovy = WW'(st_in[k].ry) >= dsh;
      end else begin
        dsh = WW'(st_in[k].d) << (NS - 1 - k);
        if (WW'(st_in[k].rx) >= dsh) begin
          st_nxt[k].rx = pcm_pkg::MAG_W'(WW'(st_in[k].rx) - dsh);
          st_nxt[k].qx[NS-1-k] = 1'b1;
        end
        if (WW'(st_in[k].ry) >= dsh) begin
          st_nxt[k].ry = pcm_pkg::MAG_W'(WW'(st_in[k].ry) - dsh);
          st_nxt[k].qy[NS-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in[k];
      end
      if (rdy[k] && v_in[k]) st_r[k] <= st_nxt[k];
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_div = st_r[NS-1];

endmodule

// ----- rtl/core/perspective_coordinate_map.sv -----
// perspective coordinate map
// maps an output pixel (column, row) through a 3x3 projective matrix to a
// source coordinate, truncated toward zero and clipped to signed 16 bits.
// in_ channel: in_tdata carries one pixel coordinate word per handshake.
// out_ channel: out_tdata carries the source coordinate, out_tuser flags.
// cfg_ channel: register index and data, always ready; to be written only while
//   no word is in flight, which the block itself does not enforce.
// 20 register stages: two for the products and magnitudes, 17 divider
//   stages and one output register.
// throughput: one word per cycle while out_tready does not stall, set by the one-bit-per-stage divider.
// each stage holds when its successor is full and stalled, so a stall on out_tready
//   fills bubbles first and then backs up to in_tready; nothing is lost.
// reset clears every valid bit and loads the identity matrix.
module perspective_coordinate_map #(
  parameter int SRC_COLS = pcm_pkg::SRC_COLS_DEF,
  parameter int SRC_ROWS = pcm_pkg::SRC_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // out_col, out_row
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // src_x, src_y
  output logic [2:0]                      out_tuser,  // in_range, zero_denominator, saturated
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pcm_pkg::coef_t coef_r;
  logic           mag_valid, mag_ready, div_valid, div_ready;
  pcm_pkg::mag_t  mag;
  pcm_pkg::div_t  dv;
  logic           out_valid_r;
  logic [31:0]    tdata_r, tdata_nxt;
  logic [2:0]     tuser_r, tuser_nxt;
  logic [15:0]    sx, sy;
  logic           satx, saty, inx, iny;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.xc <= pcm_pkg::COEF_ONE;
      coef_r.xr <= '0;
      coef_r.yc <= '0;
      coef_r.yr <= pcm_pkg::COEF_ONE;
      coef_r.wc <= '0;
      coef_r.wr <= '0;
      coef_r.xo <= '0;
      coef_r.yo <= '0;
      coef_r.wo <= pcm_pkg::COEF_ONE;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcm_pkg::REG_X_LINEAR: begin
          coef_r.xc <= cfg_data[31:0];
          coef_r.xr <= cfg_data[63:32];
        end
        pcm_pkg::REG_Y_LINEAR: begin
          coef_r.yc <= cfg_data[31:0];
          coef_r.yr <= cfg_data[63:32];
        end
        pcm_pkg::REG_W_LINEAR: begin
          coef_r.wc <= cfg_data[31:0];
          coef_r.wr <= cfg_data[63:32];
        end
        pcm_pkg::REG_OFFSET: begin
          coef_r.xo <= cfg_data[31:0];
          coef_r.yo <= cfg_data[63:32];
        end
        pcm_pkg::REG_W_OFFSET: begin
          coef_r.wo <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  pcm_front u_front (
    .clk(clk), .rst_n(rst_n), .coef(coef_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .col(in_tdata[7:0]), .row(in_tdata[15:8]),
    .out_valid(mag_valid), .out_ready(mag_ready), .out_mag(mag)
  );

  pcm_div u_div (
    .clk(clk), .rst_n(rst_n),
    .in_valid(mag_valid), .in_ready(mag_ready), .in_mag(mag),
    .out_valid(div_valid), .out_ready(div_ready), .out_div(dv)
  );

  // sign, clip and range
  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    if (dv.ovx) begin
      satx = 1'b1;
      sx = dv.negx ? 16'h8000 : 16'h7fff;
    end else if (dv.negx) begin
      satx = dv.qx > 16'h8000;
      sx = satx ? 16'h8000 : 16'(-dv.qx);
    end else begin
      satx = dv.qx[15];
      sx = satx ? 16'h7fff : dv.qx;
    end
    if (dv.ovy) begin
      saty = 1'b1;
      sy = dv.negy ? 16'h8000 : 16'h7fff;
    end else if (dv.negy) begin
      saty = dv.qy > 16'h8000;
      sy = saty ? 16'h8000 : 16'(-dv.qy);
    end else begin
      saty = dv.qy[15];
      sy = saty ? 16'h7fff : dv.qy;
    end
    inx = !dv.ovx && (!dv.negx || dv.qx == '0) && (17'(dv.qx) < 17'(SRC_COLS));
    iny = !dv.ovy && (!dv.negy || dv.qy == '0) && (17'(dv.qy) < 17'(SRC_ROWS));
    if (dv.zero) begin
      tdata_nxt = '0;
      tuser_nxt = 3'b010;
    end else begin
      tdata_nxt = {sy, sx};
      tuser_nxt = {satx || saty, 1'b0, inx && iny};
    end
  end

  assign div_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
    if (div_ready && div_valid) begin
      tdata_r <= tdata_nxt;
      tuser_r <= tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = tdata_r;
  assign out_tuser = tuser_r;

endmodule

// ----- rtl/core/pcm_checker.sv -----
`include "perspective_coordinate_map_macros.svh"

module pcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  `PCM_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")
  `PCM_ASSERT_CLK(a_zero_den, out_tvalid && out_tuser[1] |-> out_tdata == 32'h0 && !out_tuser[0] && !out_tuser[2], "zero denominator word not cleared")
  `PCM_ASSERT_CLK(a_in_range, out_tvalid && out_tuser[0] |-> !out_tuser[1] && !out_tuser[2] && !out_tdata[15] && !out_tdata[31], "in range word inconsistent")
  `PCM_ASSERT_CLK(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled word changed")

endmodule

bind perspective_coordinate_map pcm_checker u_pcm_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
